// ----- sv/pbm_pkg.sv -----
package pbm_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPACITY    = 2'd1;

    // Blend mode codes; unused codes act as normal
    localparam logic [2:0] MODE_NORMAL     = 3'd0;
    localparam logic [2:0] MODE_MULTIPLY   = 3'd1;
    localparam logic [2:0] MODE_SCREEN     = 3'd2;
    localparam logic [2:0] MODE_OVERLAY    = 3'd3;
    localparam logic [2:0] MODE_DIFFERENCE = 3'd4;

    localparam logic [2:0] MODE_RESET    = MODE_NORMAL;
    localparam logic [8:0] OPACITY_ONE   = 9'd256;
    localparam logic [8:0] OPACITY_RESET = OPACITY_ONE;

    // Load strobes for the lane pipeline stages
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
    } pbm_stage_en_t;

    // floor(x / 255) for x < 65280: reciprocal estimate, then one correction
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [23:0] scaled;
        logic [7:0]  est;
        logic [15:0] back;
        logic [15:0] rem;
        scaled = {8'd0, x} + {x, 8'd0};
        est    = scaled[23:16];
        back   = {est, 8'd0} - {8'd0, est};
        rem    = x - back;
        if (rem >= 16'd255) begin
            est = est + 8'd1;
        end
        return est;
    endfunction

endpackage

// ----- sv/pixel_blend_modes_core.sv -----
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_base_{red,green,blue}, s_layer_{red,green,blue}
// m_      | out       | m_valid / m_ready  | m_out_{red,green,blue}
// cfg_    | in        | cfg_valid / ready  | cfg_index, cfg_data
//
// One pixel per cycle sustained while m_ready stays high; each pixel passes through
// the three lane stages and then the output register.
// Three channel lanes run side by side; each holds one 8x8 and two 8x9 multipliers.
// Synchronous active-low reset clears stage valids and sets mode normal, opacity 1.0.
// A stalled output fills pipeline bubbles first; input ready drops only once all
// stages hold a pixel.
module pixel_blend_modes_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_base_red,
    input  logic [7:0]                     s_base_green,
    input  logic [7:0]                     s_base_blue,
    input  logic [7:0]                     s_layer_red,
    input  logic [7:0]                     s_layer_green,
    input  logic [7:0]                     s_layer_blue,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [7:0]                     m_out_red,
    output logic [7:0]                     m_out_green,
    output logic [7:0]                     m_out_blue,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [8:0]                     cfg_data
);
    import pbm_pkg::*;

    // Configuration registers
    logic [2:0] mode_reg;
    logic [8:0] opacity_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_RESET;
            opacity_reg <= OPACITY_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_BLEND_MODE) begin
                mode_reg <= cfg_data[2:0];
            end else if (cfg_index == REG_OPACITY) begin
                opacity_reg <= cfg_data;
            end
        end
    end

    // Stage valids and bubble-collapsing ready chain
    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic rdy1, rdy2, rdy3, rdyo;
    pbm_stage_en_t stage_en;

    always_comb begin
        rdyo = !vo_reg || m_ready;
        rdy3 = !v3_reg || rdyo;
        rdy2 = !v2_reg || rdy3;
        rdy1 = !v1_reg || rdy2;
        stage_en.ld1 = rdy1 && s_valid;
        stage_en.ld2 = rdy2 && v1_reg;
        stage_en.ld3 = rdy3 && v2_reg;
    end

    assign s_ready = rdy1;
    assign m_valid = vo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdyo) vo_reg <= v3_reg;
        end
    end

    // Channel lanes
    logic [7:0] mix_red, mix_green, mix_blue;

    pbm_lane u_lane_red (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .blend_mode (mode_reg),
        .opacity_q8 (opacity_reg),
        .base_ch    (s_base_red),
        .layer_ch   (s_layer_red),
        .mix_ch     (mix_red)
    );

    pbm_lane u_lane_green (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .blend_mode (mode_reg),
        .opacity_q8 (opacity_reg),
        .base_ch    (s_base_green),
        .layer_ch   (s_layer_green),
        .mix_ch     (mix_green)
    );

    pbm_lane u_lane_blue (
        .aclk       (aclk),
        .stage_en   (stage_en),
        .blend_mode (mode_reg),
        .opacity_q8 (opacity_reg),
        .base_ch    (s_base_blue),
        .layer_ch   (s_layer_blue),
        .mix_ch     (mix_blue)
    );

    // Merge lanes into the output register
    logic [7:0] out_red_reg, out_green_reg, out_blue_reg;

    always_ff @(posedge aclk) begin
        if (rdyo && v3_reg) begin
            out_red_reg   <= mix_red;
            out_green_reg <= mix_green;
            out_blue_reg  <= mix_blue;
        end
    end

    assign m_out_red   = out_red_reg;
    assign m_out_green = out_green_reg;
    assign m_out_blue  = out_blue_reg;

endmodule

// ----- sv/pbm_lane.sv -----
module pbm_lane (
    input  logic                  aclk,
    input  pbm_pkg::pbm_stage_en_t stage_en,
    input  logic [2:0]            blend_mode,
    input  logic [8:0]            opacity_q8,
    input  logic [7:0]            base_ch,
    input  logic [7:0]            layer_ch,
    output logic [7:0]            mix_ch
);
    import pbm_pkg::*;

    // Stage 1: one 8x8 product with rounding term
    logic [7:0]  a1_reg, b1_reg;
    logic [15:0] x1_reg;
    logic [15:0] x1_next;
    logic        use_inv;
    logic [7:0]  op_a, op_b;
    logic [15:0] prod;

    always_comb begin
        use_inv = (blend_mode == MODE_SCREEN) ||
                  ((blend_mode == MODE_OVERLAY) && base_ch[7]);
        op_a    = use_inv ? (8'd255 - base_ch)  : base_ch;
        op_b    = use_inv ? (8'd255 - layer_ch) : layer_ch;
        prod    = 16'(op_a) * 16'(op_b);
        case (blend_mode)
            MODE_MULTIPLY, MODE_SCREEN: begin
                x1_next = prod + 16'd127;
            end
            MODE_OVERLAY: begin
                x1_next = base_ch[7] ? ({prod[14:0], 1'b0} + 16'd254)
                                     : {prod[14:0], 1'b0};
            end
            default: begin
                x1_next = prod;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en.ld1) begin
            a1_reg <= base_ch;
            b1_reg <= layer_ch;
            x1_reg <= x1_next;
        end
    end

    // Stage 2: divide by 255 and pick the mode value
    logic [7:0] a2_reg, m2_reg;
    logic [7:0] m2_next;
    logic [7:0] quo;

    always_comb begin
        quo = div255(x1_reg);
        case (blend_mode)
            MODE_MULTIPLY: begin
                m2_next = quo;
            end
            MODE_SCREEN: begin
                m2_next = 8'd255 - quo;
            end
            MODE_OVERLAY: begin
                m2_next = a1_reg[7] ? (8'd255 - quo) : quo;
            end
            MODE_DIFFERENCE: begin
                m2_next = (a1_reg >= b1_reg) ? (a1_reg - b1_reg) : (b1_reg - a1_reg);
            end
            default: begin
                m2_next = b1_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (stage_en.ld2) begin
            a2_reg <= a1_reg;
            m2_reg <= m2_next;
        end
    end

    // Stage 3: opacity weighting products
    logic [8:0]  op_sat;
    logic [8:0]  op_inv;
    logic [16:0] pa3_reg, pm3_reg;

    always_comb begin
        op_sat = opacity_q8[8] ? OPACITY_ONE : opacity_q8;
        op_inv = OPACITY_ONE - op_sat;
    end

    always_ff @(posedge aclk) begin
        if (stage_en.ld3) begin
            pa3_reg <= 17'(a2_reg) * 17'(op_sat);
            pm3_reg <= 17'(m2_reg) * 17'(op_inv);
        end
    end

    // Sum, round and saturate
    logic [17:0] sum;
    always_comb begin
        sum    = {1'b0, pa3_reg} + {1'b0, pm3_reg} + 18'd128;
        mix_ch = (sum[17:16] != 2'd0) ? 8'd255 : sum[15:8];
    end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import pbm_pkg::*;

    localparam int PIPE_LATENCY = 4;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] layer_red;
        logic [7:0] layer_green;
        logic [7:0] layer_blue;
    } pixel_pair_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_base_red;
    logic [7:0]           s_base_green;
    logic [7:0]           s_base_blue;
    logic [7:0]           s_layer_red;
    logic [7:0]           s_layer_green;
    logic [7:0]           s_layer_blue;
    logic                 m_valid;
    logic                 m_ready;
    logic [7:0]           m_out_red;
    logic [7:0]           m_out_green;
    logic [7:0]           m_out_blue;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [8:0]           cfg_data;

    // Shadow copy of the blend settings, updated on each config transfer
    logic [2:0] cur_mode;
    logic [8:0] cur_opacity;

    rgb_t blended_q[$];
    int   error_count;
    int   cycle_count;
    bit   gaps_enabled;

    pixel_blend_modes_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_base_red    (s_base_red),
        .s_base_green  (s_base_green),
        .s_base_blue   (s_base_blue),
        .s_layer_red   (s_layer_red),
        .s_layer_green (s_layer_green),
        .s_layer_blue  (s_layer_blue),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 20 ns clock
    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d pixels outstanding",
                 cycle_count, blended_q.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // One channel: mode value from base a and layer b, then mixed by opacity
    function automatic logic [7:0] blend_channel(input logic [2:0] mode,
                                                 input logic [8:0] opq,
                                                 input logic [7:0] a,
                                                 input logic [7:0] b);
        int unsigned ai, bi, p, q, m, op, sum, r;
        ai = {24'd0, a};
        bi = {24'd0, b};
        p  = 255 - ai;
        q  = 255 - bi;
        case (mode)
            MODE_MULTIPLY:   m = (ai * bi + 127) / 255;
            MODE_SCREEN:     m = 255 - (p * q + 127) / 255;
            MODE_OVERLAY: begin
                if (ai < 128) m = (2 * ai * bi) / 255;
                else          m = 255 - (2 * p * q + 254) / 255;
            end
            MODE_DIFFERENCE: m = (ai >= bi) ? ai - bi : bi - ai;
            default:         m = bi;   // normal and the unused codes
        endcase
        // weights above one clamp to one
        op  = (opq > OPACITY_ONE) ? {23'd0, OPACITY_ONE} : {23'd0, opq};
        sum = ai * op + m * (256 - op) + 128;
        r   = sum >> 8;
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic rgb_t blend_pixel(input pixel_pair_t px);
        rgb_t res;
        res.red   = blend_channel(cur_mode, cur_opacity, px.base_red, px.layer_red);
        res.green = blend_channel(cur_mode, cur_opacity, px.base_green, px.layer_green);
        res.blue  = blend_channel(cur_mode, cur_opacity, px.base_blue, px.layer_blue);
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (!gaps_enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Channel value biased toward the corners and the overlay split
    function automatic logic [7:0] rand_channel();
        case ($urandom_range(0, 11))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    // Send one pixel pair; the expected blend is queued at the transfer
    task automatic send_pixel(input pixel_pair_t px);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_base_red    <= px.base_red;
        s_base_green  <= px.base_green;
        s_base_blue   <= px.base_blue;
        s_layer_red   <= px.layer_red;
        s_layer_green <= px.layer_green;
        s_layer_blue  <= px.layer_blue;
        do @(posedge aclk); while (!s_ready);
        blended_q.push_back(blend_pixel(px));
    endtask

    task automatic send_rgb(input logic [23:0] base_rgb, input logic [23:0] layer_rgb);
        send_pixel({base_rgb, layer_rgb});
    endtask

    // Drop valid and wait for every outstanding pixel to come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (blended_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_BLEND_MODE: cur_mode = data[2:0];
            REG_OPACITY:    cur_opacity = data;
            default: ;      // out-of-range index is ignored
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [8:0] mode_data, input logic [8:0] op_data);
        drain();
        write_reg(REG_BLEND_MODE, mode_data);
        write_reg(REG_OPACITY, op_data);
    endtask

    // Result sink: random stalls on m_ready
    initial begin : result_sink
        int stall_left;
        m_ready    = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 2) == 0) stall_left = pick_gap();
            end
        end
    end

    // Compare each result transfer with the oldest queued blend
    always @(posedge aclk) begin : check_results
        rgb_t want;
        if (aresetn && m_valid && m_ready) begin
            if (blended_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel %0d/%0d/%0d",
                                          m_out_red, m_out_green, m_out_blue));
            end else begin
                want = blended_q.pop_front();
                if (m_out_red !== want.red)
                    report_mismatch($sformatf("red expected %0d, got %0d",
                                              want.red, m_out_red));
                if (m_out_green !== want.green)
                    report_mismatch($sformatf("green expected %0d, got %0d",
                                              want.green, m_out_green));
                if (m_out_blue !== want.blue)
                    report_mismatch($sformatf("blue expected %0d, got %0d",
                                              want.blue, m_out_blue));
            end
        end
    end

    // Reset values: normal mode at full opacity passes the base through
    task automatic test_reset_defaults();
        send_rgb(24'h00_FF_80, 24'hFF_00_7F);
        send_rgb(24'h12_34_56, 24'hAB_CD_EF);
    endtask

    // Every mode at zero opacity, so the mode value reaches the output as is
    task automatic test_each_mode();
        logic [2:0] mode;
        for (int i = 0; i < 8; i++) begin
            mode = 3'(i);
            apply_settings({6'd0, mode}, 9'd0);
            send_rgb(24'h00_FF_80, 24'hFF_00_7F);
            if (mode <= MODE_DIFFERENCE)
                send_rgb(24'h7F_80_FF, 24'hFF_C8_FF);
        end
    endtask

    // Opacity at one, above one, the top code, half and the smallest step
    task automatic test_opacity_extremes();
        apply_settings({6'd0, MODE_SCREEN}, OPACITY_ONE);
        send_rgb(24'h10_80_F0, 24'hC0_40_20);
        apply_settings({6'd0, MODE_SCREEN}, 9'd300);
        send_rgb(24'h10_80_F0, 24'hC0_40_20);
        apply_settings({6'd0, MODE_MULTIPLY}, 9'd511);
        send_rgb(24'hFF_01_7F, 24'h00_FE_80);
        apply_settings({6'd0, MODE_OVERLAY}, 9'd128);
        send_rgb(24'h80_7F_FF, 24'hFF_FF_01);
        apply_settings({6'd0, MODE_DIFFERENCE}, 9'd1);
        send_rgb(24'hFF_00_55, 24'h00_FF_AA);
    endtask

    // Writes to unused indexes must leave both registers alone
    task automatic test_register_index_range();
        apply_settings({6'd0, MODE_MULTIPLY}, 9'd64);
        write_reg(2'd2, 9'h1FF);
        write_reg(2'd3, 9'h1AA);
        send_rgb(24'h80_40_C0, 24'h60_FF_10);
        send_rgb(24'hFF_FF_00, 24'h00_FF_FF);
    endtask

    // Phases of random pixels, each under fresh random settings
    task automatic test_random_traffic();
        pixel_pair_t px;
        logic [8:0]  mode_data;
        logic [8:0]  op_data;
        for (int phase = 0; phase < 20; phase++) begin
            gaps_enabled = (phase % 5 != 3);
            mode_data = 9'($urandom_range(0, 511));
            if (phase < 8) mode_data[2:0] = 3'(phase);
            case ($urandom_range(0, 9))
                0:       op_data = 9'd0;
                1:       op_data = OPACITY_ONE;
                2:       op_data = 9'd511;
                3:       op_data = 9'($urandom_range(257, 510));
                4:       op_data = 9'd1;
                5:       op_data = 9'd255;
                default: op_data = 9'($urandom_range(0, 256));
            endcase
            apply_settings(mode_data, op_data);
            if ($urandom_range(0, 3) == 0)
                write_reg(CFG_IDX_W'($urandom_range(2, 3)), 9'($urandom_range(0, 511)));
            repeat (100) begin
                px.base_red    = rand_channel();
                px.base_green  = rand_channel();
                px.base_blue   = rand_channel();
                px.layer_red   = rand_channel();
                px.layer_green = rand_channel();
                px.layer_blue  = rand_channel();
                send_pixel(px);
            end
        end
    endtask

    initial begin : main_sequence
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_base_red    = '0;
        s_base_green  = '0;
        s_base_blue   = '0;
        s_layer_red   = '0;
        s_layer_green = '0;
        s_layer_blue  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        cur_mode      = MODE_RESET;
        cur_opacity   = OPACITY_RESET;
        error_count   = 0;
        gaps_enabled  = 1'b1;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_each_mode();
        test_opacity_extremes();
        test_register_index_range();
        test_random_traffic();

        drain();
        repeat (2 * PIPE_LATENCY) @(posedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pbm_pkg.sv
sv/pbm_lane.sv
sv/pixel_blend_modes_core.sv
tb/testbench.sv
